### rtl/core/bnz_pkg.sv
// bnz_pkg: shared constants, types and a helper function of the bitmap next-zero search
// no dependencies; compiled first

package bnz_pkg;

   // field widths
   localparam int BIT_COUNT_W   = 13;
   localparam int START_W       = 12;
   localparam int WORD_W        = 64;
   localparam int WORD_IDX_W    = 6;
   localparam int BIT_POS_W     = 6;
   localparam int DEF_WORD_DEPTH = 64;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BIT_COUNT = 1'b0;

   // operation codes of an input item
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT
   } bnz_state_type;

   // position of the lowest set bit, zero when none is set
   function automatic logic [BIT_POS_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [BIT_POS_W-1:0] pos;
      pos = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            pos = BIT_POS_W'(b);
         end
      end
      return pos;
   endfunction

endpackage

### rtl/core/bnz_req_if.sv
// bnz_req_if: valid/ready channel carrying one request item (bitmap write or search)
// depends on bnz_pkg

interface bnz_req_if
   import bnz_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [WORD_IDX_W-1:0]  word_index;
   logic [WORD_W-1:0]      word_value;
   logic [START_W-1:0]     start_bit;

   modport source (output valid, output operation, output word_index,
                   output word_value, output start_bit, input ready);
   modport sink   (input valid, input operation, input word_index,
                   input word_value, input start_bit, output ready);
endinterface

### rtl/core/bnz_rsp_if.sv
// bnz_rsp_if: valid/ready channel carrying one search result item
// depends on bnz_pkg

interface bnz_rsp_if
   import bnz_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [BIT_COUNT_W-1:0]  next_zero_index;

   modport source (output valid, output next_zero_index, input ready);
   modport sink   (input valid, input next_zero_index, output ready);
endinterface

### rtl/core/bnz_ram.sv
// bnz_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module bnz_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/bnz_csr.sv
// bnz_csr: APB-style register file holding the bit count
// depends on bnz_pkg

module bnz_csr
   import bnz_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output logic [BIT_COUNT_W-1:0]  bit_count
);

   logic [BIT_COUNT_W-1:0] bit_count_ff;
   logic [BIT_COUNT_W-1:0] bit_count_in;
   logic                   wr_strobe;

   // write decode, word address selects the register
   assign wr_strobe = psel && penable && pwrite;

   always_comb begin
      bit_count_in = bit_count_ff;
      if (wr_strobe && (paddr[2] == REG_BIT_COUNT)) begin
         bit_count_in = pwdata[BIT_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= '0;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_BIT_COUNT) begin
         prdata = CSR_DATA_W'(bit_count_ff);
      end
   end

   assign pready    = 1'b1;
   assign bit_count = bit_count_ff;

endmodule

### rtl/core/bnz_scan.sv
// bnz_scan: request handling and word-by-word search sequencer over the bitmap RAM
// depends on bnz_pkg, bnz_req_if, bnz_rsp_if

module bnz_scan
   import bnz_pkg::*;
#(
   parameter int WORD_DEPTH = DEF_WORD_DEPTH,
   localparam int AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   bnz_req_if.sink                 req,
   bnz_rsp_if.source               rsp,
   input  logic [BIT_COUNT_W-1:0]  bit_count,
   output logic                    ram_we,
   output logic [AW-1:0]           ram_waddr,
   output logic [WORD_W-1:0]       ram_wdata,
   output logic                    ram_re,
   output logic [AW-1:0]           ram_raddr,
   input  logic [WORD_W-1:0]       ram_rdata
);

   localparam int CAP_BITS   = WORD_DEPTH * WORD_W;
   // word index wide enough for any word below the largest bit count
   localparam int SCAN_IDX_W = BIT_COUNT_W - BIT_POS_W;

   bnz_state_type state_ff, state_in;

   logic [SCAN_IDX_W-1:0]  cur_ff,      cur_in;
   logic [SCAN_IDX_W-1:0]  last_ff,     last_in;
   logic [BIT_POS_W-1:0]   start_lo_ff, start_lo_in;
   logic                   first_ff,    first_in;
   logic [BIT_COUNT_W-1:0] lim_ff,      lim_in;
   logic [BIT_COUNT_W-1:0] res_ff,      res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIT_COUNT_W-1:0] rsp_data_ff,  rsp_data_in;

   logic                   accept;
   logic [BIT_COUNT_W-1:0] lim;
   logic [BIT_COUNT_W-1:0] lim_m1;
   logic                   trivial;
   logic [WORD_W-1:0]      inv;
   logic                   found;
   logic                   scan_done;
   logic [BIT_COUNT_W-1:0] scan_res;
   logic                   out_free;

   // effective bit count, saturated to the memory size
   always_comb begin
      lim = bit_count;
      if (32'(bit_count) >= CAP_BITS) begin
         lim = BIT_COUNT_W'(CAP_BITS);
      end
   end

   assign lim_m1  = lim - BIT_COUNT_W'(1);
   assign trivial = (lim == '0) || (BIT_COUNT_W'(req.start_bit) >= lim);
   assign accept  = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // items are taken only between searches
   assign req.ready = (state_ff == ST_IDLE);

   // mask the word being checked and locate its lowest clear bit
   always_comb begin
      inv = ~ram_rdata;
      if (first_ff) begin
         inv = inv & ({WORD_W{1'b1}} << start_lo_ff);
      end
      if ((cur_ff == last_ff) && (lim_ff[BIT_POS_W-1:0] != '0)) begin
         inv = inv & ~({WORD_W{1'b1}} << lim_ff[BIT_POS_W-1:0]);
      end
   end

   assign found     = |inv;
   assign scan_done = found || (cur_ff == last_ff);
   assign scan_res  = found ? BIT_COUNT_W'({cur_ff, lowest_set(inv)}) : lim_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.operation == OP_SEARCH)) begin
               state_in = trivial ? ST_WAIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = out_free ? ST_IDLE : ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      cur_in       = cur_ff;
      last_in      = last_ff;
      start_lo_in  = start_lo_ff;
      first_in     = first_ff;
      lim_in       = lim_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = AW'(req.word_index);
      ram_wdata    = req.word_value;
      ram_raddr    = AW'(cur_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.operation == OP_WRITE)) begin
               ram_we = (32'(req.word_index) < WORD_DEPTH);
            end
            if (accept && (req.operation == OP_SEARCH)) begin
               cur_in      = SCAN_IDX_W'(req.start_bit[START_W-1:BIT_POS_W]);
               last_in     = lim_m1[BIT_COUNT_W-1:BIT_POS_W];
               start_lo_in = req.start_bit[BIT_POS_W-1:0];
               first_in    = 1'b1;
               lim_in      = lim;
               res_in      = lim;
               // first word read goes out with the accept
               ram_re      = !trivial;
               ram_raddr   = AW'(req.start_bit[START_W-1:BIT_POS_W]);
            end
         end
         ST_SCAN: begin
            first_in = 1'b0;
            if (scan_done) begin
               res_in = scan_res;
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = scan_res;
               end
            end else begin
               cur_in    = cur_ff + SCAN_IDX_W'(1);
               ram_re    = 1'b1;
               ram_raddr = AW'(cur_ff + SCAN_IDX_W'(1));
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      start_lo_ff <= start_lo_in;
      first_ff    <= first_in;
      lim_ff      <= lim_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.next_zero_index = rsp_data_ff;

endmodule

### rtl/core/bitmap_next_zero_search.sv
// Bitmap next-clear-bit search. A write item stores one 64-bit bitmap word and gives no
// result. A search item reads one bitmap word per cycle from the word holding start_bit up
// to the word holding the answer or the last counted word, through the single read port of
// the bitmap RAM. A search with a zero count or a start at or past the count reads no word.
// The result leaves through an output register, so the next item is taken while a result
// waits. bit_count is written through the APB port at byte address 0, and the search
// saturates it to WORD_DEPTH*64; write it only while the block is idle.
// Depends on bnz_pkg, bnz_req_if, bnz_rsp_if, bnz_ram, bnz_csr, bnz_scan.

module bitmap_next_zero_search
   import bnz_pkg::*;
#(
   parameter int WORD_DEPTH = DEF_WORD_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   bnz_req_if.sink                req_chan,
   bnz_rsp_if.source              rsp_chan,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

   logic [BIT_COUNT_W-1:0] bit_count;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [WORD_W-1:0]      ram_wdata;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [WORD_W-1:0]      ram_rdata;

   // configuration registers
   bnz_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .bit_count (bit_count)
   );

   // bitmap storage
   bnz_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_DEPTH)
   ) u_bitmap_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // search sequencer
   bnz_scan #(
      .WORD_DEPTH (WORD_DEPTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .bit_count (bit_count),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // a write and a search read never share a cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("bitmap RAM written and read in the same cycle");

   // every search read stays inside the memory
   a_raddr_range: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (32'(ram_raddr) < WORD_DEPTH))
      else $error("bitmap read address beyond depth");

   // the cycle after a search item is accepted, no new item is taken
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.operation == OP_SEARCH))
      |=> !req_chan.ready)
      else $error("new item taken right after a search item");

endmodule

### tb/bitmap_next_zero_search_tb.sv
// bitmap_next_zero_search_tb: self-checking testbench of the bitmap next-clear-bit search
// drives bitmap writes, searches and bit_count register writes, predicts every result
// depends on bnz_pkg, bnz_req_if, bnz_rsp_if and bitmap_next_zero_search

module bitmap_next_zero_search_tb;
   import bnz_pkg::*;

   localparam int WORD_DEPTH     = DEF_WORD_DEPTH;
   localparam int BITMAP_BITS    = WORD_DEPTH * WORD_W;
   localparam int SETTLE_CYCLES  = 80;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [CSR_ADDR_W-1:0] BIT_COUNT_ADDR = CSR_ADDR_W'(4 * REG_BIT_COUNT);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR    = CSR_ADDR_W'(4);
   localparam logic [WORD_W-1:0]     ALL_ONES       = {WORD_W{1'b1}};

   logic                   clock;
   logic                   reset;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CSR_ADDR_W-1:0]  paddr;
   logic [CSR_DATA_W-1:0]  pwdata;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   bnz_req_if req_bus ();
   bnz_rsp_if rsp_bus ();

   // predictor state: bitmap copy, which words hold data, current bit_count
   logic [WORD_W-1:0]       bitmap_words [WORD_DEPTH];
   bit                      word_written [WORD_DEPTH];
   logic [BIT_COUNT_W-1:0]  count_setting;
   logic [BIT_COUNT_W-1:0]  pending_next_zero [$];

   int  send_idle_pct = 30;
   int  recv_idle_pct = 75;
   bit  stall_request = 1'b0;
   int  mismatch_count = 0;

   bitmap_next_zero_search i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // bit_count as the search sees it, saturated to the bitmap size
   function automatic int effective_count();
      return (count_setting < BITMAP_BITS) ? int'(count_setting) : BITMAP_BITS;
   endfunction

   // lowest clear bit at or after start and below the count, else the count;
   // missing_word names the first never-written word the scan would touch
   function automatic logic [BIT_COUNT_W-1:0] predict_next_zero(
         input logic [START_W-1:0] start, output int missing_word);
      int limit, first_word, last_word, pos;
      logic [WORD_W-1:0] clear_bits;
      missing_word = -1;
      limit = effective_count();
      if (limit == 0 || start >= limit) begin
         return BIT_COUNT_W'(limit);
      end
      first_word = start >> 6;
      last_word = (limit - 1) >> 6;
      for (int w = first_word; w <= last_word; w++) begin
         if (!word_written[w]) begin
            missing_word = w;
            return BIT_COUNT_W'(limit);
         end
         clear_bits = ~bitmap_words[w];
         // drop bits below the start in the first word
         if (w == first_word) begin
            clear_bits &= ~((64'd1 << start[5:0]) - 64'd1);
         end
         // drop bits at or past the count in a partial last word
         if (w == last_word && (limit % WORD_W) != 0) begin
            clear_bits &= (64'd1 << (limit % WORD_W)) - 64'd1;
         end
         if (clear_bits != '0) begin
            pos = 0;
            while (!clear_bits[pos]) pos++;
            return BIT_COUNT_W'(w * WORD_W + pos);
         end
      end
      return BIT_COUNT_W'(limit);
   endfunction

   // offer one item after a random gap, update the prediction when accepted
   task automatic send_item(input logic op, input logic [WORD_IDX_W-1:0] idx,
         input logic [WORD_W-1:0] val, input logic [START_W-1:0] start);
      int unused_word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.word_index <= idx;
      req_bus.word_value <= val;
      req_bus.start_bit  <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (op == OP_WRITE) begin
         bitmap_words[idx] = val;
         word_written[idx] = 1'b1;
      end else begin
         pending_next_zero.push_back(predict_next_zero(start, unused_word));
      end
   endtask

   // stop offering items, wait for all results and for a scan still in flight
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (pending_next_zero.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write with setup and access cycles, only while the block is idle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
         input logic [CSR_DATA_W-1:0] data);
      drain_block();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if ((addr >> 2) == REG_BIT_COUNT) begin
         count_setting = data[BIT_COUNT_W-1:0];
      end
   endtask

   // random write or search; a search that would touch an unwritten word
   // turns into a write of that word
   task automatic send_random_item(input int write_pct);
      logic [START_W-1:0]     start;
      logic [WORD_IDX_W-1:0]  idx;
      logic [WORD_W-1:0]      val;
      logic [BIT_COUNT_W-1:0] unused_index;
      int limit, last_word, missing, roll;
      limit = effective_count();
      last_word = (limit > 0) ? (limit - 1) >> 6 : WORD_DEPTH - 1;
      roll = $urandom_range(99);
      if (limit > 0 && roll < 70) begin
         start = START_W'($urandom_range(limit - 1));
      end else if (roll < 85) begin
         // first or last bit of some word
         start = START_W'($urandom_range(last_word) * WORD_W
                          + $urandom_range(1) * (WORD_W - 1));
      end else if (roll < 93 && limit < BITMAP_BITS) begin
         start = START_W'($urandom_range(BITMAP_BITS - 1, limit));
      end else begin
         start = START_W'($urandom_range(BITMAP_BITS - 1));
      end
      unused_index = predict_next_zero(start, missing);
      roll = $urandom_range(99);
      if (roll < 35) begin
         val = ALL_ONES;
      end else if (roll < 60) begin
         val = ~(64'd1 << $urandom_range(WORD_W - 1));
      end else if (roll < 75) begin
         val = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      end else if (roll < 93) begin
         val = {$urandom, $urandom};
      end else begin
         val = '0;
      end
      if (missing >= 0 || $urandom_range(99) < write_pct) begin
         if (missing >= 0) begin
            idx = WORD_IDX_W'(missing);
         end else if ($urandom_range(3) != 0) begin
            idx = WORD_IDX_W'($urandom_range(last_word));
         end else begin
            idx = WORD_IDX_W'($urandom_range(WORD_DEPTH - 1));
         end
         send_item(OP_WRITE, idx, val, START_W'($urandom));
      end else begin
         send_item(OP_SEARCH, WORD_IDX_W'($urandom), val, start);
      end
   endtask

   // zero count right after reset: any start returns zero, no word is read
   task automatic test_empty_count();
      send_item(OP_SEARCH, '0, '0, '0);
      send_item(OP_SEARCH, '1, ALL_ONES, START_W'(BITMAP_BITS - 1));
   endtask

   // hand-built bitmap: masking of first and partial last word, late starts
   task automatic test_directed_scan();
      csr_write(BIT_COUNT_ADDR, 32'd200);
      send_item(OP_WRITE, 6'd0, ALL_ONES, START_W'($urandom));
      send_item(OP_WRITE, 6'd1, ~(64'd1 << 63), START_W'($urandom));
      send_item(OP_WRITE, 6'd2, ALL_ONES, START_W'($urandom));
      send_item(OP_WRITE, 6'd3, ~(64'd1 << 10), START_W'($urandom));
      send_item(OP_WRITE, 6'd63, ALL_ONES, START_W'($urandom));
      send_item(OP_SEARCH, '0, '0, 12'd0);
      send_item(OP_SEARCH, '0, '0, 12'd127);
      // clear bit sits past the count in the partial last word
      send_item(OP_SEARCH, '0, '0, 12'd128);
      send_item(OP_SEARCH, '0, '0, 12'd199);
      // start at the count and far past it
      send_item(OP_SEARCH, '0, '0, 12'd200);
      send_item(OP_SEARCH, '0, '0, 12'd4095);
      send_item(OP_WRITE, 6'd0, '0, START_W'($urandom));
      send_item(OP_SEARCH, '0, '0, 12'd0);
      send_item(OP_SEARCH, '0, '0, 12'd63);
      send_item(OP_WRITE, 6'd0, ~(64'd1 << 5), START_W'($urandom));
      send_item(OP_SEARCH, '0, '0, 12'd5);
      // bits below the start are masked in the first word
      send_item(OP_SEARCH, '0, '0, 12'd6);
   endtask

   // bit_count only takes its low bits, other addresses are ignored
   task automatic test_register_writes();
      csr_write(BIT_COUNT_ADDR, 32'hFFFF_E000 | 32'd203);
      send_item(OP_SEARCH, '0, '0, 12'd128);
      csr_write(BIT_COUNT_ADDR, 32'd202);
      send_item(OP_SEARCH, '0, '0, 12'd128);
      csr_write(UNUSED_ADDR, 32'd0);
      send_item(OP_SEARCH, '0, '0, 12'd128);
   endtask

   // one count setting with mostly searches over a random bitmap
   task automatic test_random_search(input int num_items, input logic [CSR_DATA_W-1:0] count);
      csr_write(BIT_COUNT_ADDR, count);
      repeat (num_items) send_random_item(30);
   endtask

   // receiver holds off while long scans keep coming, so the input stalls
   task automatic test_backpressure();
      csr_write(BIT_COUNT_ADDR, BITMAP_BITS);
      for (int w = 0; w < WORD_DEPTH; w++) begin
         send_item(OP_WRITE, WORD_IDX_W'(w), ALL_ONES, START_W'($urandom));
      end
      stall_request = 1'b1;
      repeat (24) send_random_item(0);
   endtask

   // result side readiness, with a long hold-off on request
   initial begin : result_sink
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            hold_left = RX_HOLD_CYCLES;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin : result_check
      logic [BIT_COUNT_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_next_zero.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result item: next_zero_index %0d",
                        rsp_bus.next_zero_index);
            end
         end else begin
            want = pending_next_zero.pop_front();
            if (rsp_bus.next_zero_index !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("next_zero_index mismatch: expected %0d, got %0d",
                           want, rsp_bus.next_zero_index);
               end
            end
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
               || (psel && penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   // reset, then the tests in turn
   initial begin
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_WRITE;
      req_bus.word_index <= '0;
      req_bus.word_value <= '0;
      req_bus.start_bit  <= '0;
      count_setting = '0;
      for (int w = 0; w < WORD_DEPTH; w++) begin
         word_written[w] = 1'b0;
         bitmap_words[w] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles less than receiver
      send_idle_pct = 30;
      recv_idle_pct = 75;
      test_empty_count();
      test_directed_scan();
      test_register_writes();
      test_random_search(150, BITMAP_BITS);
      test_random_search(100, $urandom_range(BITMAP_BITS));
      test_random_search(60, WORD_W);

      // receiver idles less than sender
      send_idle_pct = 75;
      recv_idle_pct = 30;
      test_random_search(120, 32'h1FFF);
      test_random_search(40, 32'd1);
      test_random_search(100, $urandom_range(BITMAP_BITS));
      test_random_search(60, BITMAP_BITS - 1);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_search(100, $urandom_range(BITMAP_BITS));
      test_random_search(20, 32'd0);
      test_random_search(70, BITMAP_BITS / 2);

      drain_block();
      if (mismatch_count == 0 && pending_next_zero.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
